@@ rtl/qrm_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, payload types and stage types for the quaternion to matrix core
package qrm_pkg;

  localparam int IN_WIDTH      = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_WIDTH     = OUT_FRAC_BITS + 2;
  localparam int PROD_WIDTH    = 2 * IN_WIDTH;
  localparam int NORM_WIDTH    = PROD_WIDTH + 1;
  localparam int NUM_WIDTH     = NORM_WIDTH + 1;
  localparam int REM_WIDTH     = NORM_WIDTH + 1;
  localparam int DIV_STEPS     = OUT_FRAC_BITS + 2;
  localparam int QUO_WIDTH     = DIV_STEPS;
  localparam int N_ENT         = 9;

  localparam logic signed [OUT_WIDTH-1:0] OUT_ONE = OUT_WIDTH'(1) << OUT_FRAC_BITS;

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] quat_w;
    logic signed [IN_WIDTH-1:0] quat_x;
    logic signed [IN_WIDTH-1:0] quat_y;
    logic signed [IN_WIDTH-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] m00;
    logic signed [OUT_WIDTH-1:0] m01;
    logic signed [OUT_WIDTH-1:0] m02;
    logic signed [OUT_WIDTH-1:0] m10;
    logic signed [OUT_WIDTH-1:0] m11;
    logic signed [OUT_WIDTH-1:0] m12;
    logic signed [OUT_WIDTH-1:0] m20;
    logic signed [OUT_WIDTH-1:0] m21;
    logic signed [OUT_WIDTH-1:0] m22;
    logic                        degenerate;
  } mat_t;

  typedef struct packed {
    logic signed [PROD_WIDTH-1:0] ww;
    logic signed [PROD_WIDTH-1:0] xx;
    logic signed [PROD_WIDTH-1:0] yy;
    logic signed [PROD_WIDTH-1:0] zz;
    logic signed [PROD_WIDTH-1:0] xy;
    logic signed [PROD_WIDTH-1:0] xz;
    logic signed [PROD_WIDTH-1:0] yz;
    logic signed [PROD_WIDTH-1:0] wx;
    logic signed [PROD_WIDTH-1:0] wy;
    logic signed [PROD_WIDTH-1:0] wz;
  } prod_t;

  typedef struct packed {
    logic [N_ENT-1:0]                neg;
    logic [N_ENT-1:0][REM_WIDTH-1:0] rem;
    logic [N_ENT-1:0][QUO_WIDTH-1:0] quo;
    logic [REM_WIDTH-1:0]            den;
    logic                            degenerate;
  } div_t;

endpackage

@@ rtl/qrm_products.sv @@
`timescale 1ns / 1ps
// input stage: the ten component products of one quaternion
module qrm_products (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  qrm_pkg::quat_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output qrm_pkg::prod_t out_data
);

  localparam int PW = qrm_pkg::PROD_WIDTH;

  logic           valid;
  qrm_pkg::prod_t data;
  qrm_pkg::prod_t data_next;

  assign in_ready = !valid || out_ready;

  always_comb begin
    data_next.ww = PW'(in_data.quat_w) * PW'(in_data.quat_w);
    data_next.xx = PW'(in_data.quat_x) * PW'(in_data.quat_x);
    data_next.yy = PW'(in_data.quat_y) * PW'(in_data.quat_y);
    data_next.zz = PW'(in_data.quat_z) * PW'(in_data.quat_z);
    data_next.xy = PW'(in_data.quat_x) * PW'(in_data.quat_y);
    data_next.xz = PW'(in_data.quat_x) * PW'(in_data.quat_z);
    data_next.yz = PW'(in_data.quat_y) * PW'(in_data.quat_z);
    data_next.wx = PW'(in_data.quat_w) * PW'(in_data.quat_x);
    data_next.wy = PW'(in_data.quat_w) * PW'(in_data.quat_y);
    data_next.wz = PW'(in_data.quat_w) * PW'(in_data.quat_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

@@ rtl/qrm_numer.sv @@
`timescale 1ns / 1ps
// two stages: numerators and squared norm, then magnitude, sign and divider setup
module qrm_numer (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  qrm_pkg::prod_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output qrm_pkg::div_t  out_data
);

  localparam int NW  = qrm_pkg::NUM_WIDTH;
  localparam int NRW = qrm_pkg::NORM_WIDTH;
  localparam int RW  = qrm_pkg::REM_WIDTH;
  localparam int NE  = qrm_pkg::N_ENT;

  function automatic logic signed [NW-1:0] ext(input logic signed [qrm_pkg::PROD_WIDTH-1:0] p);
    return NW'(p);
  endfunction

  logic                          a_valid;
  logic                          a_ready;
  logic signed [NW-1:0]          a_num [NE];
  logic [NRW-1:0]                a_n2;
  logic signed [NW-1:0]          num_next [NE];
  logic signed [NW-1:0]          n2_sum;

  logic                          valid;
  qrm_pkg::div_t                 data;
  qrm_pkg::div_t                 data_next;

  assign a_ready  = !valid || out_ready;
  assign in_ready = !a_valid || a_ready;

  always_comb begin
    n2_sum      = ext(in_data.ww) + ext(in_data.xx) + ext(in_data.yy) + ext(in_data.zz);
    num_next[0] = ext(in_data.ww) + ext(in_data.xx) - ext(in_data.yy) - ext(in_data.zz);
    num_next[1] = (ext(in_data.xy) - ext(in_data.wz)) <<< 1;
    num_next[2] = (ext(in_data.xz) + ext(in_data.wy)) <<< 1;
    num_next[3] = (ext(in_data.xy) + ext(in_data.wz)) <<< 1;
    num_next[4] = ext(in_data.ww) - ext(in_data.xx) + ext(in_data.yy) - ext(in_data.zz);
    num_next[5] = (ext(in_data.yz) - ext(in_data.wx)) <<< 1;
    num_next[6] = (ext(in_data.xz) - ext(in_data.wy)) <<< 1;
    num_next[7] = (ext(in_data.yz) + ext(in_data.wx)) <<< 1;
    num_next[8] = ext(in_data.ww) - ext(in_data.xx) - ext(in_data.yy) + ext(in_data.zz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_num <= num_next;
      a_n2  <= NRW'(n2_sum);
    end
  end

  // magnitude over doubled norm keeps the first remainder below the divisor
  always_comb begin
    logic signed [NW-1:0] mag;
    for (int k = 0; k < NE; k++) begin
      data_next.neg[k] = a_num[k][NW-1];
      mag              = a_num[k][NW-1] ? -a_num[k] : a_num[k];
      data_next.rem[k] = RW'(mag);
      data_next.quo[k] = '0;
    end
    data_next.den        = {a_n2, 1'b0};
    data_next.degenerate = (a_n2 == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (a_ready) begin
      valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

@@ rtl/qrm_div_step.sv @@
`timescale 1ns / 1ps
// one restoring division step for all nine entries, one register stage
module qrm_div_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  qrm_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output qrm_pkg::div_t out_data
);

  localparam int RW = qrm_pkg::REM_WIDTH;
  localparam int QW = qrm_pkg::QUO_WIDTH;
  localparam int NE = qrm_pkg::N_ENT;

  logic          valid;
  qrm_pkg::div_t data;
  qrm_pkg::div_t data_next;

  assign in_ready = !valid || out_ready;

  always_comb begin
    logic [RW:0] trial;
    logic [RW:0] den_ext;
    logic        ge;
    data_next = in_data;
    den_ext   = {1'b0, in_data.den};
    for (int k = 0; k < NE; k++) begin
      trial            = {in_data.rem[k], 1'b0};
      ge               = (trial >= den_ext);
      data_next.rem[k] = ge ? RW'(trial - den_ext) : RW'(trial);
      data_next.quo[k] = {in_data.quo[k][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

@@ rtl/qrm_finish.sv @@
`timescale 1ns / 1ps
// output stage: rounding, clamp, sign and identity for a zero quaternion
module qrm_finish (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  qrm_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output qrm_pkg::mat_t out_data
);

  localparam int OW = qrm_pkg::OUT_WIDTH;
  localparam int QW = qrm_pkg::QUO_WIDTH;
  localparam int NE = qrm_pkg::N_ENT;
  localparam logic [OW-1:0] ONE = qrm_pkg::OUT_ONE;

  logic          valid;
  qrm_pkg::mat_t data;
  qrm_pkg::mat_t data_next;
  logic [OW-1:0] ent [NE];

  assign in_ready = !valid || out_ready;

  // quotient carries one extra bit: add one and halve to round half away from zero
  always_comb begin
    logic [QW:0]   sum;
    logic [OW-1:0] q;
    logic [OW-1:0] mag;
    for (int k = 0; k < NE; k++) begin
      sum = {1'b0, in_data.quo[k]} + (QW + 1)'(1);
      q   = OW'(sum[QW:1]);
      mag = (q > ONE) ? ONE : q;
      if (in_data.degenerate) begin
        ent[k] = (k % 4 == 0) ? ONE : '0;
      end else begin
        ent[k] = in_data.neg[k] ? -mag : mag;
      end
    end
    data_next.m00        = ent[0];
    data_next.m01        = ent[1];
    data_next.m02        = ent[2];
    data_next.m10        = ent[3];
    data_next.m11        = ent[4];
    data_next.m12        = ent[5];
    data_next.m20        = ent[6];
    data_next.m21        = ent[7];
    data_next.m22        = ent[8];
    data_next.degenerate = in_data.degenerate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

@@ rtl/quaternion_to_rotation_matrix_core.sv @@
`timescale 1ns / 1ps
// quaternion to 3x3 rotation matrix core, top level
// throughput: one quaternion per cycle while mat_ready is not held low; every stage holds its own request
// depth is set by the divider: one quotient bit per stage over 16 stages
// reset clears the stage valid bits only; payload registers are not reset
module quaternion_to_rotation_matrix_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           quat_valid,
  output logic           quat_ready,
  input  qrm_pkg::quat_t quat,
  output logic           mat_valid,
  input  logic           mat_ready,
  output qrm_pkg::mat_t  mat
);

  localparam int STEPS = qrm_pkg::DIV_STEPS;

  logic           prod_valid;
  logic           prod_ready;
  qrm_pkg::prod_t prod_data;

  logic           div_valid [STEPS+1];
  logic           div_ready [STEPS+1];
  qrm_pkg::div_t  div_data  [STEPS+1];

  qrm_products u_products (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (quat_valid),
    .in_ready  (quat_ready),
    .in_data   (quat),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_data)
  );

  qrm_numer u_numer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod_data),
    .out_valid (div_valid[0]),
    .out_ready (div_ready[0]),
    .out_data  (div_data[0])
  );

  for (genvar s = 0; s < STEPS; s++) begin : g_div
    qrm_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_valid[s]),
      .in_ready  (div_ready[s]),
      .in_data   (div_data[s]),
      .out_valid (div_valid[s+1]),
      .out_ready (div_ready[s+1]),
      .out_data  (div_data[s+1])
    );
  end

  qrm_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid[STEPS]),
    .in_ready  (div_ready[STEPS]),
    .in_data   (div_data[STEPS]),
    .out_valid (mat_valid),
    .out_ready (mat_ready),
    .out_data  (mat)
  );

`ifndef SYNTHESIS
  a_identity: assert property (@(posedge clk) disable iff (rst)
    mat_valid && mat.degenerate |->
      mat.m00 == qrm_pkg::OUT_ONE && mat.m11 == qrm_pkg::OUT_ONE &&
      mat.m22 == qrm_pkg::OUT_ONE && mat.m01 == '0 && mat.m10 == '0 && mat.m21 == '0)
    else $error("zero quaternion did not give identity");

  a_range: assert property (@(posedge clk) disable iff (rst)
    mat_valid |->
      mat.m00 <= qrm_pkg::OUT_ONE && mat.m00 >= -qrm_pkg::OUT_ONE &&
      mat.m11 <= qrm_pkg::OUT_ONE && mat.m11 >= -qrm_pkg::OUT_ONE &&
      mat.m22 <= qrm_pkg::OUT_ONE && mat.m22 >= -qrm_pkg::OUT_ONE &&
      mat.m01 <= qrm_pkg::OUT_ONE && mat.m01 >= -qrm_pkg::OUT_ONE)
    else $error("matrix entry outside plus or minus one");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    !mat_valid |-> quat_ready)
    else $error("pipeline stalled with empty output stage");
`endif

endmodule

@@ test/quaternion_to_rotation_matrix_core_check.sv @@
`timescale 1ns / 1ps
// checker for the quaternion to matrix core: predicts each matrix and compares the outputs
module quaternion_to_rotation_matrix_core_check
  import qrm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  quat_valid,
  input  logic  quat_ready,
  input  quat_t quat,
  input  logic  mat_valid,
  input  logic  mat_ready,
  input  mat_t  mat,
  output int    fail_count,
  output int    pending_count,
  output int    matched_count,
  output int    degenerate_count
);

  localparam int MAX_SHOWN = 10;

  string entry_name [N_ENT] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

  mat_t expected_mats [$];
  int   fails      = 0;
  int   shown      = 0;
  int   matched    = 0;
  int   degenerate = 0;

  function automatic logic [OUT_WIDTH-1:0] scaled_entry(longint num, longint norm2);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    // quotient with one extra bit, then round half away from zero
    q = ((mag * (longint'(1) << (OUT_FRAC_BITS + 1))) / norm2 + 1) >>> 1;
    if (q > longint'(OUT_ONE)) q = longint'(OUT_ONE);
    if (num < 0) q = -q;
    return q[OUT_WIDTH-1:0];
  endfunction

  function automatic mat_t rotation_of(quat_t q);
    longint w, x, y, z, norm2;
    longint num [N_ENT];
    mat_t   m;
    w = longint'($signed(q.quat_w));
    x = longint'($signed(q.quat_x));
    y = longint'($signed(q.quat_y));
    z = longint'($signed(q.quat_z));
    norm2 = w * w + x * x + y * y + z * z;
    m = '0;
    if (norm2 == 0) begin
      m.m00 = OUT_ONE;
      m.m11 = OUT_ONE;
      m.m22 = OUT_ONE;
      m.degenerate = 1'b1;
    end else begin
      num[0] = w * w + x * x - y * y - z * z;
      num[1] = 2 * (x * y - w * z);
      num[2] = 2 * (x * z + w * y);
      num[3] = 2 * (x * y + w * z);
      num[4] = w * w - x * x + y * y - z * z;
      num[5] = 2 * (y * z - w * x);
      num[6] = 2 * (x * z - w * y);
      num[7] = 2 * (y * z + w * x);
      num[8] = w * w - x * x - y * y + z * z;
      for (int k = 0; k < N_ENT; k++) begin
        m[1 + OUT_WIDTH * (N_ENT - 1 - k) +: OUT_WIDTH] = scaled_entry(num[k], norm2);
      end
    end
    return m;
  endfunction

  always @(posedge clk) begin
    mat_t want;
    logic signed [OUT_WIDTH-1:0] want_e, got_e;
    if (!rst) begin
      if (quat_valid && quat_ready) expected_mats.push_back(rotation_of(quat));
      if (mat_valid && mat_ready) begin
        if (expected_mats.size() == 0) begin
          fails++;
          if (shown < MAX_SHOWN) begin
            shown++;
            $display("unexpected matrix with no request outstanding: %h", mat);
          end
        end else begin
          want = expected_mats.pop_front();
          matched++;
          if (want.degenerate) degenerate++;
          for (int k = 0; k < N_ENT; k++) begin
            want_e = want[1 + OUT_WIDTH * (N_ENT - 1 - k) +: OUT_WIDTH];
            got_e  = mat[1 + OUT_WIDTH * (N_ENT - 1 - k) +: OUT_WIDTH];
            if (want_e !== got_e) begin
              fails++;
              if (shown < MAX_SHOWN) begin
                shown++;
                $display("matrix %0d %s: expected %0d, got %0d", matched, entry_name[k],
                         want_e, got_e);
              end
            end
          end
          if (want.degenerate !== mat.degenerate) begin
            fails++;
            if (shown < MAX_SHOWN) begin
              shown++;
              $display("matrix %0d degenerate: expected %0b, got %0b", matched,
                       want.degenerate, mat.degenerate);
            end
          end
        end
      end
    end
    fail_count       <= fails;
    pending_count    <= expected_mats.size();
    matched_count    <= matched;
    degenerate_count <= degenerate;
  end

endmodule

@@ test/quaternion_to_rotation_matrix_core_test.sv @@
`timescale 1ns / 1ps
// testbench top for the quaternion to matrix core: clock, reset, stimulus and verdict
module quaternion_to_rotation_matrix_core_test;
  import qrm_pkg::*;

  localparam int RANDOM_ITEMS  = 1830;
  localparam int IDLE_LIMIT    = 5000;
  localparam int HOLD_OFF      = 400;
  localparam int HOLD_OFF_AT   = 610;
  localparam int DRAIN_CYCLES  = 40;

  logic  clk;
  logic  rst;
  logic  quat_valid;
  logic  quat_ready;
  quat_t quat;
  logic  mat_valid;
  logic  mat_ready;
  mat_t  mat;

  int fail_count, pending_count, matched_count, degenerate_count;
  int sent_count  = 0;
  int idle_cycles = 0;

  quaternion_to_rotation_matrix_core uut (
    .clk        (clk),
    .rst        (rst),
    .quat_valid (quat_valid),
    .quat_ready (quat_ready),
    .quat       (quat),
    .mat_valid  (mat_valid),
    .mat_ready  (mat_ready),
    .mat        (mat)
  );

  quaternion_to_rotation_matrix_core_check checker_i (
    .clk              (clk),
    .rst              (rst),
    .quat_valid       (quat_valid),
    .quat_ready       (quat_ready),
    .quat             (quat),
    .mat_valid        (mat_valid),
    .mat_ready        (mat_ready),
    .mat              (mat),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .matched_count    (matched_count),
    .degenerate_count (degenerate_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (quat_valid && quat_ready) || (mat_valid && mat_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no request or matrix moved for %0d cycles", IDLE_LIMIT);
      $display("quaternion_to_rotation_matrix_core_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic quat_t make_quat(int w, int x, int y, int z);
    quat_t q;
    q.quat_w = w[IN_WIDTH-1:0];
    q.quat_x = x[IN_WIDTH-1:0];
    q.quat_y = y[IN_WIDTH-1:0];
    q.quat_z = z[IN_WIDTH-1:0];
    return q;
  endfunction

  function automatic int pick_component();
    int extremes [6] = '{-32768, 32767, -32767, 4096, -4096, 1};
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(0, 16) - 8;
      2:       return extremes[$urandom_range(0, 5)];
      3:       return $urandom_range(0, 8192) - 4096;
      default: return int'($signed(16'($urandom_range(0, 65535))));
    endcase
  endfunction

  task automatic send_quat(quat_t q, int gap);
    repeat (gap) begin
      @(negedge clk);
      quat_valid <= 1'b0;
    end
    @(negedge clk);
    quat       <= q;
    quat_valid <= 1'b1;
    do @(posedge clk); while (!(quat_valid && quat_ready));
    sent_count++;
  endtask

  // receiver: random stalls, calm stretches, and one long hold-off to back the pipe up
  initial begin
    int stall;
    int taken;
    mat_ready = 1'b0;
    taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken == HOLD_OFF_AT) stall = HOLD_OFF;
      else if ((taken / 170) % 3 == 2) stall = 0;
      else stall = $urandom_range(0, 19);
      repeat (stall) begin
        @(negedge clk);
        mat_ready <= 1'b0;
      end
      @(negedge clk);
      mat_ready <= 1'b1;
      do @(posedge clk); while (!(mat_valid && mat_ready));
      taken++;
    end
  end

  initial begin
    quat_t directed [$];
    quat_t q;
    int    gap;
    rst        = 1'b1;
    quat_valid = 1'b0;
    quat       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero quaternion, unit axes, extremes, non-unit and tiny norms
    directed.push_back(make_quat(0, 0, 0, 0));
    directed.push_back(make_quat(4096, 0, 0, 0));
    directed.push_back(make_quat(0, 4096, 0, 0));
    directed.push_back(make_quat(0, 0, 4096, 0));
    directed.push_back(make_quat(0, 0, 0, 4096));
    directed.push_back(make_quat(-32768, 0, 0, 0));
    directed.push_back(make_quat(0, -32768, 0, 0));
    directed.push_back(make_quat(0, 0, -32768, 0));
    directed.push_back(make_quat(0, 0, 0, -32768));
    directed.push_back(make_quat(-32768, -32768, -32768, -32768));
    directed.push_back(make_quat(32767, 32767, 32767, 32767));
    directed.push_back(make_quat(32767, -32768, 32767, -32768));
    directed.push_back(make_quat(-32768, 32767, -32768, 32767));
    directed.push_back(make_quat(1, 0, 0, 0));
    directed.push_back(make_quat(0, 0, 0, -1));
    directed.push_back(make_quat(1, 1, 1, 1));
    directed.push_back(make_quat(-1, -1, -1, -1));
    directed.push_back(make_quat(2896, 2896, 0, 0));
    directed.push_back(make_quat(3, -7, 11, 5));
    directed.push_back(make_quat(0, 0, 0, 0));
    foreach (directed[i]) send_quat(directed[i], $urandom_range(0, 3));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 39) == 0) q = make_quat(0, 0, 0, 0);
      else q = make_quat(pick_component(), pick_component(), pick_component(),
                         pick_component());
      gap = ((i / 150) % 3 == 1) ? 0 : $urandom_range(0, 19);
      send_quat(q, gap);
    end
    @(negedge clk);
    quat_valid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d quaternions, %0d matrices checked, %0d of them degenerate",
             sent_count, matched_count, degenerate_count);
    $display("random stalls on both sides with calm stretches and a %0d-cycle output hold-off",
             HOLD_OFF);
    if (fail_count == 0 && pending_count == 0) begin
      $display("quaternion_to_rotation_matrix_core_test: done, clean");
    end else begin
      $display("%0d mismatches, %0d matrices never arrived", fail_count, pending_count);
      $display("quaternion_to_rotation_matrix_core_test: done, errors");
    end
    $finish;
  end

endmodule
